/* src/vms_pkg.sv */
package vms_pkg;

    localparam int ModeW  = 4;
    localparam int CmdW   = 2;
    localparam int TimeW  = 64;
    localparam int CountW = 32;
    localparam int ReqW   = 7;
    localparam int RdyW   = 5;
    localparam int PrgW   = 4;

    typedef logic [ModeW-1:0] t_mode;
    typedef logic [CmdW-1:0]  t_cmd;

    // Mode codes
    localparam t_mode MODE_BOOT       = 4'd0;
    localparam t_mode MODE_SENSOR_CAL = 4'd1;
    localparam t_mode MODE_IDLE       = 4'd2;
    localparam t_mode MODE_S1_REC     = 4'd3;
    localparam t_mode MODE_S1_DONE    = 4'd4;
    localparam t_mode MODE_REVERSE    = 4'd5;
    localparam t_mode MODE_FINISHED   = 4'd6;
    localparam t_mode MODE_FAULT      = 4'd7;
    localparam t_mode MODE_CAL        = 4'd8;

    // Command codes
    localparam t_cmd CMD_UPDATE = 2'd0;
    localparam t_cmd CMD_TAKE   = 2'd1;
    localparam t_cmd CMD_INIT   = 2'd2;

    // Request flag bits
    localparam int RQ_CAL     = 0;
    localparam int RQ_IDLE    = 1;
    localparam int RQ_S1_GO   = 2;
    localparam int RQ_S1_STOP = 3;
    localparam int RQ_STOP    = 4;
    localparam int RQ_S2_GO   = 5;
    localparam int RQ_FRESET  = 6;

    // Readiness flag bits
    localparam int RD_FAULT   = 0;
    localparam int RD_BOOTED  = 1;
    localparam int RD_DRIVERS = 2;
    localparam int RD_SENS_OK = 3;
    localparam int RD_CAL_OK  = 4;

    // Progress flag bits
    localparam int PG_S1_LIM    = 0;
    localparam int PG_PATH_DONE = 1;
    localparam int PG_PATH_OK   = 2;
    localparam int PG_REV_DONE  = 3;

    typedef struct packed {
        t_cmd             command;
        logic [TimeW-1:0] timestamp;
        logic [ReqW-1:0]  request_flags;
        logic [RdyW-1:0]  readiness_flags;
        logic [PrgW-1:0]  progress_flags;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_slot;

endpackage

/* src/vehicle_mode_sequencer.sv */
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------------------
// input    | in        | i_in_valid / o_in_stall   | command, timestamp, request, readiness,
//          |           |                           | progress flags
// output   | out       | o_out_valid / i_out_stall | changed, current/prior mode, entry time,
//          |           |                           | transitions, entry_taken, automatic_res
//
// Every transaction passes through the mode decode: input register, then
// next-mode logic and state update into the result register, which drives
// o_out_valid. One transaction per cycle is sustained while the output does not
// stall; the mode register feeding the decode sets that figure.
// Reset (i_rst_n low, synchronous) returns to boot with an entry pending and
// empties both registers. A stall on the output holds the result and backs
// up into the input register, which then raises o_in_stall.
module vehicle_mode_sequencer
    import vms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CmdW-1:0]   i_command,
    input  logic [TimeW-1:0]  i_timestamp,
    input  logic [ReqW-1:0]   i_request_flags,
    input  logic [RdyW-1:0]   i_readiness_flags,
    input  logic [PrgW-1:0]   i_progress_flags,

    // Output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_changed,
    output logic [ModeW-1:0]  o_current_mode,
    output logic [ModeW-1:0]  o_prior_mode,
    output logic [TimeW-1:0]  o_entry_time,
    output logic [CountW-1:0] o_transitions,
    output logic              o_entry_taken,
    output logic              o_automatic_res
);

    t_item      in_item;
    t_item_slot slot;
    logic       take;

    // Bundle the input transaction fields
    assign in_item.command         = i_command;
    assign in_item.timestamp       = i_timestamp;
    assign in_item.request_flags   = i_request_flags;
    assign in_item.readiness_flags = i_readiness_flags;
    assign in_item.progress_flags  = i_progress_flags;

    // Hold the accepted transaction until the core takes it
    vms_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_stall (o_in_stall),
        .i_take  (take),
        .o_slot  (slot)
    );

    // Decode the next mode, advance state and register the result
    vms_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slot          (slot),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_changed       (o_changed),
        .o_current_mode  (o_current_mode),
        .o_prior_mode    (o_prior_mode),
        .o_entry_time    (o_entry_time),
        .o_transitions   (o_transitions),
        .o_entry_taken   (o_entry_taken),
        .o_automatic_res (o_automatic_res)
    );

endmodule

/* src/vms_in_reg.sv */
module vms_in_reg
    import vms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_stall,
    input  logic       i_take,
    output t_item_slot o_slot
);

    logic  r_vld;
    t_item r_item;

    assign o_stall = r_vld && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    // Load a new transaction whenever the slot is free or drains this cycle
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_slot.valid = r_vld;
    assign o_slot.item  = r_item;

endmodule

/* src/vms_next_mode.sv */
module vms_next_mode
    import vms_pkg::*;
(
    input  t_mode           i_mode,
    input  logic [ReqW-1:0] i_req,
    input  logic [RdyW-1:0] i_rdy,
    input  logic [PrgW-1:0] i_prg,
    output t_mode           o_next
);

    always_comb begin
        o_next = i_mode;
        if (i_rdy[RD_FAULT] && i_mode != MODE_FAULT) begin
            o_next = MODE_FAULT;
        end else begin
            unique case (i_mode)
                MODE_BOOT: begin
                    if (i_rdy[RD_BOOTED]) begin
                        o_next = i_rdy[RD_DRIVERS] ? MODE_SENSOR_CAL : MODE_FAULT;
                    end
                end
                MODE_SENSOR_CAL: begin
                    priority if (i_req[RQ_CAL]) begin
                        o_next = MODE_CAL;
                    end else if (i_req[RQ_IDLE] || i_rdy[RD_SENS_OK]) begin
                        o_next = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                    priority if (i_req[RQ_CAL]) begin
                        o_next = MODE_CAL;
                    end else if (i_req[RQ_S1_GO] && i_rdy[RD_CAL_OK]) begin
                        o_next = MODE_S1_REC;
                    end
                end
                MODE_S1_REC: begin
                    if (i_req[RQ_S1_STOP] || i_req[RQ_STOP] || i_prg[PG_S1_LIM]) begin
                        o_next = MODE_S1_DONE;
                    end
                end
                MODE_S1_DONE: begin
                    priority if (i_prg[PG_PATH_DONE] && !i_prg[PG_PATH_OK]) begin
                        o_next = MODE_FAULT;
                    end else if (i_req[RQ_S2_GO] && i_prg[PG_PATH_OK]
                                 && i_rdy[RD_CAL_OK]) begin
                        o_next = MODE_REVERSE;
                    end else if (i_req[RQ_CAL]) begin
                        o_next = MODE_CAL;
                    end
                end
                MODE_REVERSE: begin
                    priority if (i_prg[PG_REV_DONE]) begin
                        o_next = MODE_FINISHED;
                    end else if (i_req[RQ_STOP]) begin
                        o_next = MODE_S1_DONE;
                    end
                end
                MODE_FINISHED: begin
                    if (i_req[RQ_IDLE]) begin
                        o_next = MODE_IDLE;
                    end
                end
                MODE_FAULT: begin
                    if (i_req[RQ_FRESET] && !i_rdy[RD_FAULT]) begin
                        o_next = i_rdy[RD_CAL_OK] ? MODE_IDLE : MODE_CAL;
                    end
                end
                MODE_CAL: begin
                    priority if (i_req[RQ_IDLE] || i_req[RQ_STOP]) begin
                        o_next = MODE_IDLE;
                    end else if (i_req[RQ_S1_GO] && i_rdy[RD_CAL_OK]) begin
                        o_next = MODE_S1_REC;
                    end
                end
                default: begin
                    o_next = MODE_FAULT;
                end
            endcase
        end
    end

endmodule

/* src/vms_core.sv */
module vms_core
    import vms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item_slot        i_slot,
    output logic              o_take,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_changed,
    output t_mode             o_current_mode,
    output t_mode             o_prior_mode,
    output logic [TimeW-1:0]  o_entry_time,
    output logic [CountW-1:0] o_transitions,
    output logic              o_entry_taken,
    output logic              o_automatic_res
);

    // Architectural state
    t_mode             r_mode,       n_mode;
    t_mode             r_last,       n_last;
    logic [TimeW-1:0]  r_entry_time, n_entry_time;
    logic [CountW-1:0] r_count,      n_count;
    logic              r_pending,    n_pending;

    // Result register
    logic r_out_vld;
    logic r_out_changed, n_changed;
    logic r_out_taken,   n_taken;
    t_mode             r_out_mode;
    t_mode             r_out_last;
    logic [TimeW-1:0]  r_out_time;
    logic [CountW-1:0] r_out_count;

    t_mode decoded;
    logic  fire;

    assign o_take = !r_out_vld || !i_out_stall;
    assign fire   = i_slot.valid && o_take;

    vms_next_mode u_next (
        .i_mode (r_mode),
        .i_req  (i_slot.item.request_flags),
        .i_rdy  (i_slot.item.readiness_flags),
        .i_prg  (i_slot.item.progress_flags),
        .o_next (decoded)
    );

    always_comb begin
        n_mode       = r_mode;
        n_last       = r_last;
        n_entry_time = r_entry_time;
        n_count      = r_count;
        n_pending    = r_pending;
        n_changed    = 1'b0;
        n_taken      = 1'b0;
        unique case (i_slot.item.command)
            CMD_UPDATE: begin
                if (decoded != r_mode) begin
                    n_last       = r_mode;
                    n_mode       = decoded;
                    n_entry_time = i_slot.item.timestamp;
                    n_count      = r_count + CountW'(1);
                    n_pending    = 1'b1;
                    n_changed    = 1'b1;
                end
            end
            CMD_TAKE: begin
                n_taken   = r_pending;
                n_pending = 1'b0;
            end
            CMD_INIT: begin
                n_mode       = MODE_BOOT;
                n_last       = MODE_BOOT;
                n_entry_time = i_slot.item.timestamp;
                n_count      = '0;
                n_pending    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_BOOT;
            r_last       <= MODE_BOOT;
            r_entry_time <= '0;
            r_count      <= '0;
            r_pending    <= 1'b1;
            r_out_vld    <= 1'b0;
        end else begin
            if (fire) begin
                r_mode       <= n_mode;
                r_last       <= n_last;
                r_entry_time <= n_entry_time;
                r_count      <= n_count;
                r_pending    <= n_pending;
                r_out_vld    <= 1'b1;
            end else if (o_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_changed <= n_changed;
            r_out_taken   <= n_taken;
            r_out_mode    <= n_mode;
            r_out_last    <= n_last;
            r_out_time    <= n_entry_time;
            r_out_count   <= n_count;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_changed       = r_out_changed;
    assign o_entry_taken   = r_out_taken;
    assign o_current_mode  = r_out_mode;
    assign o_prior_mode    = r_out_last;
    assign o_entry_time    = r_out_time;
    assign o_transitions   = r_out_count;
    assign o_automatic_res = (r_out_mode == MODE_S1_REC) || (r_out_mode == MODE_REVERSE);

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= MODE_CAL)
        else $error("mode register holds an undefined code");

    a_change_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_changed) |-> (r_out_mode != r_out_last))
        else $error("reported change with equal current and prior mode");

    a_change_or_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_changed && r_out_taken))
        else $error("change and entry take reported together");

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_slot.item.command == CMD_TAKE) |=> !r_pending)
        else $error("pending entry not cleared by take");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_slot.item.command == CMD_UPDATE && decoded != r_mode)
        |=> (r_count == CountW'($past(r_count) + CountW'(1))))
        else $error("transition count did not advance on a change");

endmodule

/* dv/vehicle_mode_sequencer_test.sv */
module vehicle_mode_sequencer_test;
    import vms_pkg::*;

    localparam int ITEM_TARGET   = 950;
    localparam int QUIET_LIMIT   = 4000;
    localparam int LONG_HOLD_LEN = 300;
    localparam int TAIL_CYCLES   = 10;

    // Spare command code: the block leaves its state alone
    localparam t_cmd CMD_SPARE = 2'd3;

    localparam logic [ReqW-1:0] RQ_CAL_M     = ReqW'(1 << RQ_CAL);
    localparam logic [ReqW-1:0] RQ_IDLE_M    = ReqW'(1 << RQ_IDLE);
    localparam logic [ReqW-1:0] RQ_S1_GO_M   = ReqW'(1 << RQ_S1_GO);
    localparam logic [ReqW-1:0] RQ_S1_STOP_M = ReqW'(1 << RQ_S1_STOP);
    localparam logic [ReqW-1:0] RQ_STOP_M    = ReqW'(1 << RQ_STOP);
    localparam logic [ReqW-1:0] RQ_S2_GO_M   = ReqW'(1 << RQ_S2_GO);
    localparam logic [ReqW-1:0] RQ_FRESET_M  = ReqW'(1 << RQ_FRESET);

    localparam logic [RdyW-1:0] RD_FAULT_M   = RdyW'(1 << RD_FAULT);
    localparam logic [RdyW-1:0] RD_BOOTED_M  = RdyW'(1 << RD_BOOTED);
    localparam logic [RdyW-1:0] RD_DRIVERS_M = RdyW'(1 << RD_DRIVERS);
    localparam logic [RdyW-1:0] RD_SENS_OK_M = RdyW'(1 << RD_SENS_OK);
    localparam logic [RdyW-1:0] RD_CAL_OK_M  = RdyW'(1 << RD_CAL_OK);

    localparam logic [PrgW-1:0] PG_S1_LIM_M    = PrgW'(1 << PG_S1_LIM);
    localparam logic [PrgW-1:0] PG_PATH_DONE_M = PrgW'(1 << PG_PATH_DONE);
    localparam logic [PrgW-1:0] PG_PATH_OK_M   = PrgW'(1 << PG_PATH_OK);
    localparam logic [PrgW-1:0] PG_REV_DONE_M  = PrgW'(1 << PG_REV_DONE);

    localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};

    typedef struct packed {
        logic              changed;
        t_mode             current_mode;
        t_mode             prior_mode;
        logic [TimeW-1:0]  entry_time;
        logic [CountW-1:0] transitions;
        logic              entry_taken;
        logic              automatic_res;
    } t_mode_report;

    class mode_tracker;
        t_mode             mode;
        t_mode             last_mode;
        logic [TimeW-1:0]  entered_at;
        logic [CountW-1:0] change_count;
        bit                pending_entry;
        t_mode_report      expected_reports[$];
        int                errors;

        function new();
            mode          = MODE_BOOT;
            last_mode     = MODE_BOOT;
            entered_at    = '0;
            change_count  = '0;
            pending_entry = 1'b1;
            errors        = 0;
        endfunction

        function t_mode next_mode_of(t_item it);
            logic [ReqW-1:0] rq;
            logic [RdyW-1:0] rd;
            logic [PrgW-1:0] pg;
            t_mode           nx;
            rq = it.request_flags;
            rd = it.readiness_flags;
            pg = it.progress_flags;
            nx = mode;
            if (rd[RD_FAULT] && mode != MODE_FAULT) return MODE_FAULT;
            case (mode)
                MODE_BOOT: begin
                    if (rd[RD_BOOTED]) nx = rd[RD_DRIVERS] ? MODE_SENSOR_CAL : MODE_FAULT;
                end
                MODE_SENSOR_CAL: begin
                    if (rq[RQ_CAL]) nx = MODE_CAL;
                    else if (rq[RQ_IDLE] || rd[RD_SENS_OK]) nx = MODE_IDLE;
                end
                MODE_IDLE: begin
                    if (rq[RQ_CAL]) nx = MODE_CAL;
                    else if (rq[RQ_S1_GO] && rd[RD_CAL_OK]) nx = MODE_S1_REC;
                end
                MODE_S1_REC: begin
                    if (rq[RQ_S1_STOP] || rq[RQ_STOP] || pg[PG_S1_LIM]) nx = MODE_S1_DONE;
                end
                MODE_S1_DONE: begin
                    if (pg[PG_PATH_DONE] && !pg[PG_PATH_OK]) nx = MODE_FAULT;
                    else if (rq[RQ_S2_GO] && pg[PG_PATH_OK] && rd[RD_CAL_OK])
                        nx = MODE_REVERSE;
                    else if (rq[RQ_CAL]) nx = MODE_CAL;
                end
                MODE_REVERSE: begin
                    if (pg[PG_REV_DONE]) nx = MODE_FINISHED;
                    else if (rq[RQ_STOP]) nx = MODE_S1_DONE;
                end
                MODE_FINISHED: begin
                    if (rq[RQ_IDLE]) nx = MODE_IDLE;
                end
                MODE_FAULT: begin
                    if (rq[RQ_FRESET] && !rd[RD_FAULT])
                        nx = rd[RD_CAL_OK] ? MODE_IDLE : MODE_CAL;
                end
                MODE_CAL: begin
                    if (rq[RQ_IDLE] || rq[RQ_STOP]) nx = MODE_IDLE;
                    else if (rq[RQ_S1_GO] && rd[RD_CAL_OK]) nx = MODE_S1_REC;
                end
                default: nx = MODE_FAULT;
            endcase
            return nx;
        endfunction

        function void note_item(t_item it);
            t_mode        nx;
            t_mode_report rep;
            rep = '0;
            case (it.command)
                CMD_UPDATE: begin
                    nx = next_mode_of(it);
                    if (nx != mode) begin
                        last_mode     = mode;
                        mode          = nx;
                        entered_at    = it.timestamp;
                        change_count  = change_count + CountW'(1);
                        pending_entry = 1'b1;
                        rep.changed   = 1'b1;
                    end
                end
                CMD_TAKE: begin
                    rep.entry_taken = pending_entry;
                    pending_entry   = 1'b0;
                end
                CMD_INIT: begin
                    mode          = MODE_BOOT;
                    last_mode     = MODE_BOOT;
                    entered_at    = it.timestamp;
                    change_count  = '0;
                    pending_entry = 1'b1;
                end
                default: ;
            endcase
            rep.current_mode  = mode;
            rep.prior_mode    = last_mode;
            rep.entry_time    = entered_at;
            rep.transitions   = change_count;
            rep.automatic_res = (mode == MODE_S1_REC) || (mode == MODE_REVERSE);
            expected_reports.push_back(rep);
        endfunction

        function void check_report(t_mode_report got);
            t_mode_report exp;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result arrived with no transaction waiting");
                return;
            end
            exp = expected_reports.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display({"report differs: exp chg=%0b cur=%0d pri=%0d t=%h n=%0d ",
                              "tk=%0b au=%0b / got chg=%0b cur=%0d pri=%0d t=%h n=%0d ",
                              "tk=%0b au=%0b"},
                             exp.changed, exp.current_mode, exp.prior_mode,
                             exp.entry_time, exp.transitions, exp.entry_taken,
                             exp.automatic_res,
                             got.changed, got.current_mode, got.prior_mode,
                             got.entry_time, got.transitions, got.entry_taken,
                             got.automatic_res);
            end
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CmdW-1:0]   i_command;
    logic [TimeW-1:0]  i_timestamp;
    logic [ReqW-1:0]   i_request_flags;
    logic [RdyW-1:0]   i_readiness_flags;
    logic [PrgW-1:0]   i_progress_flags;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_changed;
    logic [ModeW-1:0]  o_current_mode;
    logic [ModeW-1:0]  o_prior_mode;
    logic [TimeW-1:0]  o_entry_time;
    logic [CountW-1:0] o_transitions;
    logic              o_entry_taken;
    logic              o_automatic_res;

    mode_tracker      tracker = new();
    logic [TimeW-1:0] clock_us;
    bit               long_hold_req;
    int               quiet_cycles;

    vehicle_mode_sequencer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_timestamp       (i_timestamp),
        .i_request_flags   (i_request_flags),
        .i_readiness_flags (i_readiness_flags),
        .i_progress_flags  (i_progress_flags),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_changed         (o_changed),
        .o_current_mode    (o_current_mode),
        .o_prior_mode      (o_prior_mode),
        .o_entry_time      (o_entry_time),
        .o_transitions     (o_transitions),
        .o_entry_taken     (o_entry_taken),
        .o_automatic_res   (o_automatic_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic drive_item(input t_item it);
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_command         <= it.command;
        i_timestamp       <= it.timestamp;
        i_request_flags   <= it.request_flags;
        i_readiness_flags <= it.readiness_flags;
        i_progress_flags  <= it.progress_flags;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_item(it);
    endtask

    task automatic offer(input t_cmd cmd, input logic [TimeW-1:0] ts,
                         input logic [ReqW-1:0] rq, input logic [RdyW-1:0] rd,
                         input logic [PrgW-1:0] pg);
        t_item it;
        it.command         = cmd;
        it.timestamp       = ts;
        it.request_flags   = rq;
        it.readiness_flags = rd;
        it.progress_flags  = pg;
        drive_item(it);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed updates with a rare fault flag, so the walk reaches
    // the deep modes; a tenth of the items are unbiased noise.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 84)      it.command = CMD_UPDATE;
        else if (pick < 92) it.command = CMD_TAKE;
        else if (pick < 97) it.command = CMD_INIT;
        else                it.command = CMD_SPARE;
        clock_us = clock_us + TimeW'($urandom_range(1, 5000));
        if ($urandom_range(0, 15) == 0) it.timestamp = {$urandom, $urandom};
        else                            it.timestamp = clock_us;
        if ($urandom_range(0, 9) == 0) begin
            it.request_flags   = ReqW'($urandom);
            it.readiness_flags = RdyW'($urandom);
            it.progress_flags  = PrgW'($urandom);
        end else begin
            it.request_flags   = ReqW'($urandom & $urandom);
            it.readiness_flags = RdyW'($urandom);
            it.readiness_flags[RD_FAULT] = ($urandom_range(0, 11) == 0);
            it.progress_flags  = PrgW'($urandom);
        end
        return it;
    endfunction

    task automatic run_directed();
        offer(CMD_TAKE,   64'd0,   '0, '0, '0);
        offer(CMD_TAKE,   64'd0,   '0, '0, '0);
        offer(CMD_SPARE,  64'd3,   '1, '1, '1);
        offer(CMD_UPDATE, 64'd5,   '0, '0, '0);
        offer(CMD_UPDATE, 64'd10,  '0, RD_BOOTED_M, '0);
        offer(CMD_UPDATE, 64'd20,  RQ_FRESET_M, RD_FAULT_M, '0);
        offer(CMD_UPDATE, 64'd30,  RQ_FRESET_M, '0, '0);
        offer(CMD_UPDATE, 64'd40,  RQ_STOP_M, '0, '0);
        offer(CMD_INIT,   TIME_MAX, '1, '1, '1);
        offer(CMD_UPDATE, 64'd50,  '0, RD_BOOTED_M | RD_DRIVERS_M, '0);
        offer(CMD_UPDATE, 64'd60,  '0, RD_SENS_OK_M, '0);
        offer(CMD_UPDATE, 64'd70,  RQ_S1_GO_M, '0, '0);
        offer(CMD_UPDATE, 64'd80,  RQ_S1_GO_M, RD_CAL_OK_M, '0);
        offer(CMD_UPDATE, 64'd90,  '0, '0, PG_S1_LIM_M);
        offer(CMD_UPDATE, 64'd100, RQ_S2_GO_M, RD_CAL_OK_M, PG_PATH_OK_M);
        offer(CMD_UPDATE, 64'd110, RQ_STOP_M, '0, '0);
        offer(CMD_UPDATE, 64'd120, RQ_S2_GO_M, RD_CAL_OK_M, PG_PATH_OK_M | PG_PATH_DONE_M);
        offer(CMD_UPDATE, 64'd130, '0, '0, PG_REV_DONE_M);
        offer(CMD_UPDATE, 64'd140, RQ_IDLE_M, '0, '0);
        offer(CMD_UPDATE, 64'd150, RQ_CAL_M, '0, '0);
        offer(CMD_UPDATE, 64'd160, RQ_S1_GO_M, RD_CAL_OK_M, '0);
        offer(CMD_UPDATE, 64'd170, RQ_S1_STOP_M, '0, '0);
        offer(CMD_UPDATE, 64'd180, '0, '0, PG_PATH_DONE_M);
        offer(CMD_UPDATE, 64'd190, RQ_FRESET_M, RD_CAL_OK_M, '0);
        offer(CMD_TAKE,   64'd200, '0, '0, '0);
        offer(CMD_UPDATE, TIME_MAX, '1, '1, '1);
        offer(CMD_INIT,   64'd0,   '0, '0, '0);
    endtask

    // Receiver: runs of varied stall density, plus one long hold on request.
    initial begin
        int hold_left;
        int run_left;
        int style;
        hold_left   = 0;
        run_left    = 0;
        style       = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && long_hold_req) begin
                hold_left     = LONG_HOLD_LEN;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    style    = $urandom_range(0, 3);
                    run_left = $urandom_range(4, 40);
                end
                run_left--;
                case (style)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 1) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_report({o_changed, o_current_mode, o_prior_mode, o_entry_time,
                                  o_transitions, o_entry_taken, o_automatic_res});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("vehicle_mode_sequencer: mismatch");
            $finish;
        end
    end

    initial begin
        int   sent;
        int   burst;
        int   k;
        t_item it;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_command         = CMD_UPDATE;
        i_timestamp       = '0;
        i_request_flags   = '0;
        i_readiness_flags = '0;
        i_progress_flags  = '0;
        long_hold_req     = 1'b0;
        quiet_cycles      = 0;
        clock_us          = 64'd1000;
        sent              = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        while (sent < ITEM_TARGET) begin
            burst = $urandom_range(1, 32);
            for (k = 0; k < burst && sent < ITEM_TARGET; k++) begin
                it = random_item();
                drive_item(it);
                if (it.command != CMD_SPARE) begin
                    sent++;
                    if (sent == 300) long_hold_req = 1'b1;
                    if (sent == 620) begin
                        hold_off(1);
                        wait_drained();
                    end
                end
            end
            if ($urandom_range(0, 3) == 0) hold_off(0);
            else                           hold_off($urandom_range(1, 8));
        end

        hold_off(1);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.outstanding() != 0) tracker.errors++;
        if (tracker.errors == 0)
            $display("vehicle_mode_sequencer: match");
        else
            $display("vehicle_mode_sequencer: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
src/vms_pkg.sv
src/vms_in_reg.sv
src/vms_next_mode.sv
src/vms_core.sv
src/vehicle_mode_sequencer.sv
dv/vehicle_mode_sequencer_test.sv
